// ===== hw/rtl/bale_pkg.sv =====
// Shared types and constants for the bounded array list engine.
package bale_pkg;

    typedef enum logic [2:0] {
        OP_APPEND   = 3'd0,
        OP_POP_BACK = 3'd1,
        OP_POP_FRONT = 3'd2,
        OP_INSERT   = 3'd3,
        OP_REMOVE   = 3'd4,
        OP_CHANGE   = 3'd5,
        OP_GET      = 3'd6,
        OP_SEARCH   = 3'd7
    } op_t;

    typedef enum logic [2:0] {
        STS_OK       = 3'd0,
        STS_FULL     = 3'd1,
        STS_EMPTY    = 3'd2,
        STS_BADPOS   = 3'd3,
        STS_NOTFOUND = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_EXEC   = 2'd1,
        ST_SCAN   = 2'd2,
        ST_FINISH = 2'd3
    } state_t;

    typedef enum logic [1:0] {
        CMD_HOLD   = 2'd0,
        CMD_WRITE  = 2'd1,
        CMD_INSERT = 2'd2,
        CMD_REMOVE = 2'd3
    } cmd_kind_t;

    typedef struct packed {
        logic [63:0] value_out;
        logic [3:0]  found_index;
        status_t     status;
    } result_t;

    localparam logic [63:0] BLANK_WORD    = 64'h0000_0000_0000_2020;
    localparam logic [4:0]  CAPACITY_RST  = 5'd16;
    localparam int          CAP_BITS      = 5;

endpackage

// ===== hw/rtl/bale_cell.sv =====
// One list cell: holds a single entry and takes a word from itself, a neighbour or the bus.
module bale_cell #(
    parameter int WIDTH = 64,
    parameter int IDX_W = 4,
    parameter int INDEX = 0
) (
    input  logic                aclk,
    input  bale_pkg::cmd_kind_t kind,
    input  logic [IDX_W-1:0]    at_idx,
    input  logic [WIDTH-1:0]    word_in,
    input  logic [WIDTH-1:0]    left_word,
    input  logic [WIDTH-1:0]    right_word,
    output logic [WIDTH-1:0]    entry_reg
);
    import bale_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic [WIDTH-1:0] entry_next;

    always_comb begin
        entry_next = entry_reg;
        unique case (kind)
            CMD_HOLD: begin
                entry_next = entry_reg;
            end
            CMD_WRITE: begin
                if (MY_IDX == at_idx) begin
                    entry_next = word_in;
                end
            end
            CMD_INSERT: begin
                if (MY_IDX > at_idx) begin
                    entry_next = left_word;
                end else if (MY_IDX == at_idx) begin
                    entry_next = word_in;
                end
            end
            CMD_REMOVE: begin
                if (MY_IDX >= at_idx) begin
                    entry_next = right_word;
                end
            end
            default: begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule

// ===== hw/rtl/bale_chain.sv =====
// Row of list cells with neighbour links and a single read port.
module bale_chain #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 64,
    parameter int IDX_W = 4
) (
    input  logic                aclk,
    input  bale_pkg::cmd_kind_t kind,
    input  logic [IDX_W-1:0]    at_idx,
    input  logic [WIDTH-1:0]    word_in,
    input  logic [IDX_W-1:0]    rd_sel,
    output logic [WIDTH-1:0]    rd_word
);
    import bale_pkg::*;

    logic [WIDTH-1:0] cell_word [DEPTH];

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [WIDTH-1:0] left_w;
        logic [WIDTH-1:0] right_w;

        if (i == 0) begin : g_first
            assign left_w = cell_word[i];
        end else begin : g_mid_l
            assign left_w = cell_word[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign right_w = cell_word[i];
        end else begin : g_mid_r
            assign right_w = cell_word[i+1];
        end

        bale_cell #(
            .WIDTH (WIDTH),
            .IDX_W (IDX_W),
            .INDEX (i)
        ) u_cell (
            .aclk       (aclk),
            .kind       (kind),
            .at_idx     (at_idx),
            .word_in    (word_in),
            .left_word  (left_w),
            .right_word (right_w),
            .entry_reg  (cell_word[i])
        );
    end

    assign rd_word = cell_word[rd_sel];

endmodule

// ===== hw/rtl/bounded_array_list_engine_unit.sv =====
// Top level of the bounded array list engine: control, capacity register and result register.
//
// Usage:
//   s_* channel carries one operation item (op, position, value); m_* channel returns
//   exactly one result item per operation (value_out, found_index, status, entry_count).
//   cfg_valid/cfg_data write the list capacity; cfg_ready is always high. Write it only
//   while the block is idle.
//   Entries live in a row of cells; insert and remove shift all entries behind the
//   position by one place at once, so every operation other than search executes
//   in the execute state that follows acceptance. Search steps through the cells one per
//   cycle through the single read port.
//   A result is loaded into the output register from the execute state, or for a
//   search from the finish state after the scan. The next item is accepted only
//   once the control has returned to idle.
//   A new item is accepted while the previous result still waits in the output
//   register; if the receiver stalls, the next item waits in the control stage and
//   no further item is accepted until it has moved to the output register.
//   Reset empties the list, sets the capacity to 16 and drops any pending result.
module bounded_array_list_engine_unit #(
    parameter int DEPTH      = 16,
    parameter int ENTRY_BITS = 64
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_op,
    input  logic [3:0]  s_position,
    input  logic [63:0] s_value,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_value_out,
    output logic [3:0]  m_found_index,
    output logic [2:0]  m_status,
    output logic [4:0]  m_entry_count,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data
);
    import bale_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > CAP_BITS) ? CNT_W : CAP_BITS;

    state_t state_reg, state_next;

    logic [CNT_W-1:0]      count_reg, count_next;
    logic [CAP_BITS-1:0]   cap_reg;
    op_t                   op_reg;
    logic [3:0]            pos_reg;
    logic [ENTRY_BITS-1:0] val_reg;
    logic [IDX_W-1:0]      scan_reg;
    logic                  hit_reg;
    logic [IDX_W-1:0]      fidx_reg;

    logic                  m_valid_reg;
    logic [63:0]           m_value_reg;
    logic [3:0]            m_fidx_reg;
    logic [2:0]            m_status_reg;
    logic [4:0]            m_count_reg;

    logic                  slot_free;
    logic                  out_load;
    result_t               res;
    cmd_kind_t             cmd_kind;
    logic [IDX_W-1:0]      cmd_at;
    logic [IDX_W-1:0]      exec_sel;
    logic [IDX_W-1:0]      rd_sel;
    logic [ENTRY_BITS-1:0] rd_word;
    logic                  scan_match;
    logic                  scan_last;

    logic [CMP_W-1:0]      n_ext;
    logic [CMP_W-1:0]      pos_ext;
    logic [CMP_W-1:0]      cap_ext;
    logic [CMP_W-1:0]      lim;
    logic                  is_full;
    logic                  is_empty;
    logic                  is_blank;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign slot_free = !m_valid_reg || m_ready;

    assign n_ext    = CMP_W'(count_reg);
    assign pos_ext  = CMP_W'(pos_reg);
    assign cap_ext  = CMP_W'(cap_reg);
    assign lim      = (cap_ext > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : cap_ext;
    assign is_full  = (n_ext >= lim);
    assign is_empty = (count_reg == '0);
    assign is_blank = (64'(val_reg) == BLANK_WORD);

    assign rd_sel     = (state_reg == ST_SCAN) ? scan_reg : exec_sel;
    assign scan_match = (rd_word == val_reg);
    assign scan_last  = (CNT_W'(scan_reg) == count_reg - CNT_W'(1));

    bale_chain #(
        .DEPTH (DEPTH),
        .WIDTH (ENTRY_BITS),
        .IDX_W (IDX_W)
    ) u_chain (
        .aclk    (aclk),
        .kind    (cmd_kind),
        .at_idx  (cmd_at),
        .word_in (val_reg),
        .rd_sel  (rd_sel),
        .rd_word (rd_word)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (op_reg == OP_SEARCH) begin
                    state_next = is_empty ? ST_FINISH : ST_SCAN;
                end else if (slot_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN: begin
                if (scan_match || scan_last) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (slot_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        res.value_out   = '0;
        res.found_index = '0;
        res.status      = STS_OK;
        cmd_kind        = CMD_HOLD;
        cmd_at          = '0;
        exec_sel        = IDX_W'(pos_reg);
        count_next      = count_reg;
        out_load        = 1'b0;

        unique case (state_reg)
            ST_EXEC: begin
                out_load = slot_free && (op_reg != OP_SEARCH);
                unique case (op_reg)
                    OP_APPEND: begin
                        if (is_full) begin
                            res.status = STS_FULL;
                        end else if (!is_blank) begin
                            cmd_kind   = CMD_WRITE;
                            cmd_at     = IDX_W'(count_reg);
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    OP_POP_BACK: begin
                        exec_sel = IDX_W'(count_reg - CNT_W'(1));
                        if (is_empty) begin
                            res.status = STS_EMPTY;
                        end else begin
                            res.value_out = 64'(rd_word);
                            count_next    = count_reg - CNT_W'(1);
                        end
                    end
                    OP_POP_FRONT: begin
                        exec_sel = '0;
                        if (is_empty) begin
                            res.status = STS_EMPTY;
                        end else begin
                            res.value_out = 64'(rd_word);
                            cmd_kind      = CMD_REMOVE;
                            cmd_at        = '0;
                            count_next    = count_reg - CNT_W'(1);
                        end
                    end
                    OP_INSERT: begin
                        if (is_full) begin
                            res.status = STS_FULL;
                        end else if (pos_ext > n_ext) begin
                            res.status = STS_BADPOS;
                        end else begin
                            cmd_kind   = CMD_INSERT;
                            cmd_at     = IDX_W'(pos_reg);
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    OP_REMOVE: begin
                        if (is_empty) begin
                            res.status = STS_EMPTY;
                        end else if (pos_ext >= n_ext) begin
                            res.status = STS_BADPOS;
                        end else begin
                            res.value_out = 64'(rd_word);
                            cmd_kind      = CMD_REMOVE;
                            cmd_at        = IDX_W'(pos_reg);
                            count_next    = count_reg - CNT_W'(1);
                        end
                    end
                    OP_CHANGE: begin
                        if (is_empty) begin
                            res.status = STS_EMPTY;
                        end else if (pos_ext >= n_ext) begin
                            res.status = STS_BADPOS;
                        end else begin
                            cmd_kind = CMD_WRITE;
                            cmd_at   = IDX_W'(pos_reg);
                        end
                    end
                    OP_GET: begin
                        if (is_empty) begin
                            res.status = STS_EMPTY;
                        end else if (pos_ext >= n_ext) begin
                            res.status = STS_BADPOS;
                        end else begin
                            res.value_out = 64'(rd_word);
                        end
                    end
                    OP_SEARCH: begin
                        res.status = STS_NOTFOUND;
                    end
                    default: begin
                        res.status = STS_OK;
                    end
                endcase
                if (!out_load) begin
                    cmd_kind   = CMD_HOLD;
                    count_next = count_reg;
                end
            end
            ST_FINISH: begin
                out_load        = slot_free;
                res.status      = hit_reg ? STS_OK : STS_NOTFOUND;
                res.found_index = hit_reg ? 4'(fidx_reg) : 4'd0;
            end
            ST_IDLE, ST_SCAN: begin
                out_load = 1'b0;
            end
            default: begin
                out_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            cap_reg     <= CAPACITY_RST;
            m_valid_reg <= 1'b0;
            hit_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                cap_reg <= cfg_data;
            end
            if (out_load) begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (state_reg == ST_EXEC) begin
                hit_reg <= 1'b0;
            end else if (state_reg == ST_SCAN && scan_match) begin
                hit_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg  <= op_t'(s_op);
            pos_reg <= s_position;
            val_reg <= s_value[ENTRY_BITS-1:0];
        end
        if (state_reg == ST_EXEC) begin
            scan_reg <= '0;
        end else if (state_reg == ST_SCAN) begin
            if (scan_match) begin
                fidx_reg <= scan_reg;
            end
            scan_reg <= scan_reg + IDX_W'(1);
        end
        if (out_load) begin
            m_value_reg  <= res.value_out;
            m_fidx_reg   <= res.found_index;
            m_status_reg <= res.status;
            m_count_reg  <= 5'(count_next);
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_value_out   = m_value_reg;
    assign m_found_index = m_fidx_reg;
    assign m_status      = m_status_reg;
    assign m_entry_count = m_count_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count beyond depth");

    a_scan_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCAN |-> count_reg != '0)
        else $error("search scan on empty list");

    a_full_keeps_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && res.status == STS_FULL) |=> count_reg == $past(count_reg))
        else $error("refused item changed the count");

    a_count_reported: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> m_count_reg == 5'(count_reg))
        else $error("pending result count differs from held count");

endmodule

// ===== tb/bounded_array_list_engine_unit_checker.sv =====
// Checker for the bounded array list engine: predicts each result and compares it.
module bounded_array_list_engine_unit_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [2:0]  s_op,
    input  logic [3:0]  s_position,
    input  logic [63:0] s_value,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [63:0] m_value_out,
    input  logic [3:0]  m_found_index,
    input  logic [2:0]  m_status,
    input  logic [4:0]  m_entry_count,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [4:0]  cfg_data,
    output int          fail_count,
    output int          pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import bale_pkg::*;

    localparam int LIST_DEPTH = 16;

    typedef struct {
        logic [63:0] value_out;
        logic [3:0]  found_index;
        status_t     status;
        logic [4:0]  entry_count;
    } list_result_t;

    logic [63:0]  list_words [LIST_DEPTH];
    int           words_held;
    logic [4:0]   capacity;
    list_result_t expected_results [$];

    function automatic list_result_t apply_list_op(op_t op, logic [3:0] pos,
                                                   logic [63:0] word);
        list_result_t r;
        int n;
        int limit;
        int i;
        r.value_out   = '0;
        r.found_index = '0;
        r.status      = STS_OK;
        n     = words_held;
        limit = (capacity > LIST_DEPTH) ? LIST_DEPTH : int'(capacity);
        case (op)
            OP_APPEND: begin
                if (n >= limit) begin
                    r.status = STS_FULL;
                end else if (word != BLANK_WORD) begin
                    list_words[n] = word;
                    n++;
                end
            end
            OP_POP_BACK: begin
                if (n == 0) begin
                    r.status = STS_EMPTY;
                end else begin
                    n--;
                    r.value_out = list_words[n];
                end
            end
            OP_POP_FRONT: begin
                if (n == 0) begin
                    r.status = STS_EMPTY;
                end else begin
                    r.value_out = list_words[0];
                    for (i = 0; i + 1 < n; i++) list_words[i] = list_words[i + 1];
                    n--;
                end
            end
            OP_INSERT: begin
                if (n >= limit) begin
                    r.status = STS_FULL;
                end else if (pos > n) begin
                    r.status = STS_BADPOS;
                end else begin
                    for (i = n; i > pos; i--) list_words[i] = list_words[i - 1];
                    list_words[pos] = word;
                    n++;
                end
            end
            OP_REMOVE: begin
                if (n == 0) begin
                    r.status = STS_EMPTY;
                end else if (pos >= n) begin
                    r.status = STS_BADPOS;
                end else begin
                    r.value_out = list_words[pos];
                    for (i = pos; i + 1 < n; i++) list_words[i] = list_words[i + 1];
                    n--;
                end
            end
            OP_CHANGE: begin
                if (n == 0) begin
                    r.status = STS_EMPTY;
                end else if (pos >= n) begin
                    r.status = STS_BADPOS;
                end else begin
                    list_words[pos] = word;
                end
            end
            OP_GET: begin
                if (n == 0) begin
                    r.status = STS_EMPTY;
                end else if (pos >= n) begin
                    r.status = STS_BADPOS;
                end else begin
                    r.value_out = list_words[pos];
                end
            end
            default: begin
                r.status = STS_NOTFOUND;
                for (i = n - 1; i >= 0; i--) begin
                    if (list_words[i] == word) begin
                        r.found_index = i[3:0];
                        r.status      = STS_OK;
                    end
                end
            end
        endcase
        words_held    = n;
        r.entry_count = n[4:0];
        return r;
    endfunction

    task automatic check_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        list_result_t want;
        if (!aresetn) begin
            words_held = 0;
            capacity   = CAPACITY_RST;
            expected_results.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                capacity = cfg_data;
            end
            if (s_valid && s_ready) begin
                expected_results.push_back(apply_list_op(op_t'(s_op), s_position, s_value));
            end
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result with none expected, value_out %0h status %0d",
                             $time, m_value_out, m_status);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("value_out", want.value_out, m_value_out);
                    check_field("found_index", 64'(want.found_index), 64'(m_found_index));
                    check_field("status", 64'(want.status), 64'(m_status));
                    check_field("entry_count", 64'(want.entry_count), 64'(m_entry_count));
                end
            end
        end
        pending_count = expected_results.size();
    end

endmodule

// ===== tb/bounded_array_list_engine_unit_tb.sv =====
// Testbench top for the bounded array list engine: clock, reset, stimulus and verdict.
module bounded_array_list_engine_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bale_pkg::*;

    localparam int HOLD_OFF_CYCLES = 60;
    localparam int WATCHDOG_LIMIT  = 1000;
    localparam op_t SHRINK_OPS [6] = '{OP_POP_BACK, OP_POP_FRONT, OP_REMOVE,
                                       OP_CHANGE, OP_GET, OP_SEARCH};

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [2:0]  s_op;
    logic [3:0]  s_position;
    logic [63:0] s_value;
    logic        m_valid;
    logic        m_ready;
    logic [63:0] m_value_out;
    logic [3:0]  m_found_index;
    logic [2:0]  m_status;
    logic [4:0]  m_entry_count;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [4:0]  cfg_data;
    int          fail_count;
    int          pending_count;

    bit          quiet_mode;
    bit          hold_off_request;
    logic [63:0] word_pool [8];

    bounded_array_list_engine_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_position    (s_position),
        .s_value       (s_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_value_out   (m_value_out),
        .m_found_index (m_found_index),
        .m_status      (m_status),
        .m_entry_count (m_entry_count),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    bounded_array_list_engine_unit_checker list_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_position    (s_position),
        .s_value       (s_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_value_out   (m_value_out),
        .m_found_index (m_found_index),
        .m_status      (m_status),
        .m_entry_count (m_entry_count),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_request) begin
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge aclk);
                hold_off_request = 1'b0;
            end
            m_ready <= quiet_mode || ($urandom_range(0, 99) >= 6);
        end
    end

    initial begin
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (cfg_valid && cfg_ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
        end
        $display("bounded_array_list_engine_unit: mismatch");
        $finish;
    end

    task automatic send_item(input op_t op, input logic [3:0] pos, input logic [63:0] word);
        @(negedge aclk);
        while (!quiet_mode && $urandom_range(0, 99) < 6) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_op       <= op;
        s_position <= pos;
        s_value    <= word;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        wait (pending_count == 0);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_capacity(input logic [4:0] cap);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= cap;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_random_item(input int grow_pct);
        op_t         op;
        logic [3:0]  pos;
        logic [63:0] word;
        int          pick;
        if ($urandom_range(0, 99) < grow_pct) begin
            op = ($urandom_range(0, 1) != 0) ? OP_INSERT : OP_APPEND;
        end else begin
            op = SHRINK_OPS[3'($urandom_range(0, 5))];
        end
        pos  = ($urandom_range(0, 1) != 0) ? 4'($urandom_range(0, 15))
                                           : 4'($urandom_range(0, 3));
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            word = word_pool[3'($urandom_range(0, 7))];
        end else if (pick < 76) begin
            word = BLANK_WORD;
        end else begin
            word = {$urandom, $urandom};
        end
        send_item(op, pos, word);
    endtask

    task automatic run_phase(input logic [4:0] cap, input int items, input int grow_pct,
                             input bit calm, input bit with_hold);
        int k;
        drain_results();
        write_capacity(cap);
        for (k = 0; k < 8; k++) word_pool[3'(k)] = {$urandom, $urandom};
        word_pool[1] = '1;
        word_pool[2] = '0;
        quiet_mode = calm;
        for (k = 0; k < items; k++) begin
            if (with_hold && k == items / 4) hold_off_request = 1'b1;
            send_random_item(grow_pct);
        end
        quiet_mode = 1'b0;
    endtask

    initial begin
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_op       = OP_APPEND;
        s_position = '0;
        s_value    = '0;
        cfg_valid  = 1'b0;
        cfg_data   = CAPACITY_RST;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        write_capacity(5'd3);
        send_item(OP_POP_BACK,  4'd0,  '0);
        send_item(OP_POP_FRONT, 4'd0,  '0);
        send_item(OP_REMOVE,    4'd0,  '0);
        send_item(OP_CHANGE,    4'd0,  64'h1);
        send_item(OP_GET,       4'd0,  '0);
        send_item(OP_SEARCH,    4'd0,  '0);
        send_item(OP_APPEND,    4'd0,  BLANK_WORD);
        send_item(OP_APPEND,    4'd0,  '1);
        send_item(OP_INSERT,    4'd0,  '0);
        send_item(OP_INSERT,    4'd15, 64'h7777);
        send_item(OP_INSERT,    4'd2,  64'h0123_4567_89ab_cdef);
        send_item(OP_APPEND,    4'd0,  64'h5);
        send_item(OP_INSERT,    4'd0,  64'h6);
        send_item(OP_APPEND,    4'd0,  BLANK_WORD);
        send_item(OP_GET,       4'd0,  '0);
        send_item(OP_GET,       4'd3,  '0);
        send_item(OP_CHANGE,    4'd1,  64'h5555_5555_5555_5555);
        send_item(OP_SEARCH,    4'd0,  64'h5555_5555_5555_5555);
        send_item(OP_SEARCH,    4'd0,  64'hdead);
        send_item(OP_REMOVE,    4'd15, '0);
        send_item(OP_REMOVE,    4'd1,  '0);
        send_item(OP_POP_FRONT, 4'd0,  '0);
        send_item(OP_POP_BACK,  4'd0,  '0);
        send_item(OP_GET,       4'd0,  '0);

        run_phase(5'd16, 200, 60, 1'b0, 1'b0);
        run_phase(5'd2,  120, 30, 1'b0, 1'b0);
        run_phase(5'd0,   60, 40, 1'b0, 1'b0);
        run_phase(5'd31, 200, 55, 1'b1, 1'b0);
        run_phase(5'd1,   80, 50, 1'b0, 1'b0);
        run_phase(5'($urandom_range(1, 16)), 200, 45, 1'b0, 1'b1);
        run_phase(5'd16, 270, 35, 1'b0, 1'b0);

        @(negedge aclk);
        s_valid <= 1'b0;
        wait (pending_count == 0);
        repeat (20) @(posedge aclk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("bounded_array_list_engine_unit: match");
        end else begin
            $display("bounded_array_list_engine_unit: mismatch");
        end
        $finish;
    end

endmodule
